// File: design/distance_constraint_solver_top_assert.svh
// Assertion macros used by the distance constraint solver checker.
`ifndef DISTANCE_CONSTRAINT_SOLVER_TOP_ASSERT_SVH
`define DISTANCE_CONSTRAINT_SOLVER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcs assertion failed");

// next-cycle implication, disabled in reset
`define DCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcs assertion failed");

`endif

// File: design/dcs_pkg.sv
// Shared widths, register indexes, item type and helpers of the distance constraint solver.
package dcs_pkg;

    localparam int CoordW    = 32;
    localparam int DiffW     = 33;
    localparam int MassW     = 24;
    localparam int TotW      = 25;
    localparam int LenW      = 33;
    localparam int SqW       = 64;
    localparam int RadW      = 66;
    localparam int RemW      = 36;
    localparam int RestW     = 31;
    localparam int StiffW    = 17;
    localparam int CfgDataW  = 31;
    localparam int CfgIdxW   = 1;
    localparam int SumW      = 35;

    localparam int SqrtCells = RadW / 2;
    localparam int DirFrac   = 30;
    localparam int DirQW     = DirFrac + 1;
    localparam int DirRW     = LenW + DirQW - 1;
    localparam int ShareFrac = 16;
    localparam int ShareQW   = ShareFrac + 1;
    localparam int ShareRW   = TotW + ShareQW - 1;

    localparam logic [StiffW-1:0] StiffOne = StiffW'(65536);

    localparam logic [CfgIdxW-1:0] RegRestLength = 1'b0;
    localparam logic [CfgIdxW-1:0] RegStiffness  = 1'b1;

    typedef struct packed {
        logic signed [CoordW-1:0] ax;
        logic signed [CoordW-1:0] ay;
        logic signed [CoordW-1:0] bx;
        logic signed [CoordW-1:0] by;
        logic [MassW-1:0]         wa;
        logic [MassW-1:0]         wb;
        logic signed [DiffW-1:0]  dx;
        logic signed [DiffW-1:0]  dy;
        logic [LenW-1:0]          len;
        logic                     grow;
        logic                     act;
        logic [LenW-1:0]          corr;
    } dcs_item_t;

    // magnitude of a coordinate difference; never exceeds 2^32 - 1
    function automatic logic [CoordW-1:0] mag33(input logic signed [DiffW-1:0] v);
        logic [DiffW-1:0] t;
        t = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
        return t[CoordW-1:0];
    endfunction

    function automatic logic [CoordW-1:0] sat35(input logic signed [SumW-1:0] v);
        logic [CoordW-1:0] r;
        if (v > SumW'(signed'(64'sd2147483647)))
            r = 32'h7fff_ffff;
        else if (v < SumW'(signed'(-64'sd2147483648)))
            r = 32'h8000_0000;
        else
            r = v[CoordW-1:0];
        return r;
    endfunction

endpackage

// File: design/dcs_if.sv
// Item channels and configuration write channel of the distance constraint solver.
interface dcs_in_if import dcs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic [MassW-1:0]         a_inv_mass;
    logic [MassW-1:0]         b_inv_mass;

    modport source (output valid, a_x, a_y, b_x, b_y, a_inv_mass, b_inv_mass, input ready);
    modport sink (input valid, a_x, a_y, b_x, b_y, a_inv_mass, b_inv_mass, output ready);
endinterface

interface dcs_out_if import dcs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [CoordW-1:0] new_a_x;
    logic signed [CoordW-1:0] new_a_y;
    logic signed [CoordW-1:0] new_b_x;
    logic signed [CoordW-1:0] new_b_y;

    modport source (output valid, new_a_x, new_a_y, new_b_x, new_b_y, input ready);
    modport sink (input valid, new_a_x, new_a_y, new_b_x, new_b_y, output ready);
endinterface

interface dcs_cfg_if import dcs_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CfgIdxW-1:0]   index;
    logic [CfgDataW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/dcs_sqrt_cell.sv
// One root bit of the integer square root chain.
module dcs_sqrt_cell import dcs_pkg::*; #(
    parameter int PAIR = 0
) (
    input  logic            clk,
    input  logic            en,
    input  logic [RadW-1:0] rad_in,
    input  logic [RemW-1:0] rem_in,
    input  logic [LenW-1:0] root_in,
    output logic [RadW-1:0] rad_out,
    output logic [RemW-1:0] rem_out,
    output logic [LenW-1:0] root_out
);

    logic [RadW-1:0] rad_reg;
    logic [RemW-1:0] rem_reg, rem_next;
    logic [LenW-1:0] root_reg, root_next;
    logic [RemW-1:0] rem_sh, trial;

    always_comb
    begin
        rem_sh = {rem_in[RemW-3:0], rad_in[2*PAIR+1 -: 2]};
        trial  = {1'b0, root_in, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_in[LenW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_in[LenW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// File: design/dcs_div_cell.sv
// One quotient bit of a restoring divider chain.
module dcs_div_cell #(
    parameter int DW    = 33,
    parameter int QW    = 31,
    parameter int SHIFT = 0
) (
    input  logic               clk,
    input  logic               en,
    input  logic [DW-1:0]      d_in,
    input  logic [DW+QW-2:0]   r_in,
    input  logic [QW-1:0]      q_in,
    output logic [DW-1:0]      d_out,
    output logic [DW+QW-2:0]   r_out,
    output logic [QW-1:0]      q_out
);

    localparam int RW = DW + QW - 1;

    logic [DW-1:0] d_reg;
    logic [RW-1:0] r_reg, r_next, trial;
    logic [QW-1:0] q_reg, q_next;

    always_comb
    begin
        trial  = {{(RW-DW){1'b0}}, d_in} << SHIFT;
        r_next = r_in;
        q_next = q_in;
        if (r_in >= trial)
        begin
            r_next        = r_in - trial;
            q_next[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_in;
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign d_out = d_reg;
    assign r_out = r_reg;
    assign q_out = q_reg;

endmodule

// File: design/distance_constraint_solver_top.sv
// Distance constraint solver: one point pair per cycle while the pipeline is not stopped.
// One pair is taken each such cycle. An item passes 72 pipeline stages and the output register:
// difference, squares, sum, a 33-cell square root chain (one root bit per cell), error and
// stiffness scaling, a 31-cell direction divider chain per axis with 17-cell share dividers
// beside its tail, then move, step and saturating add. The pipeline stops only when a result
// waits in the output register and another one has reached the last stage. Configuration is
// taken at any time with ready held high, but rest length and stiffness are read mid-pipeline,
// so write them only while no item is in flight.
module distance_constraint_solver_top import dcs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    dcs_cfg_if.sink    cfg,
    dcs_in_if.sink     pair,
    dcs_out_if.source  result
);

    localparam int NV       = 3 + SqrtCells + 2 + DirQW + 3;
    localparam int ShareOff = DirQW - ShareQW;

    // configuration
    logic [RestW-1:0]  rest_length_reg;
    logic [StiffW-1:0] stiffness_reg;
    logic [StiffW-1:0] stiff_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_length_reg <= '0;
            stiffness_reg   <= StiffOne;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                RegRestLength: rest_length_reg <= cfg.data[RestW-1:0];
                RegStiffness:  stiffness_reg   <= cfg.data[StiffW-1:0];
                default: ;
            endcase
        end
    end

    assign stiff_eff = (stiffness_reg > StiffOne) ? StiffOne : stiffness_reg;

    // flow control
    logic          adv, accept, out_free;
    logic [NV-1:0] vpipe_reg;
    logic          out_v_reg;

    assign out_free   = !out_v_reg || result.ready;
    assign adv        = out_free || !vpipe_reg[NV-1];
    assign pair.ready = adv;
    assign accept     = pair.valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vpipe_reg <= {vpipe_reg[NV-2:0], accept};
            if (out_free)
                out_v_reg <= vpipe_reg[NV-1];
        end
    end

    // stage 0: capture and differences
    dcs_item_t it0_next, it0_reg;

    always_comb
    begin
        it0_next    = '0;
        it0_next.ax = pair.a_x;
        it0_next.ay = pair.a_y;
        it0_next.bx = pair.b_x;
        it0_next.by = pair.b_y;
        it0_next.wa = pair.a_inv_mass;
        it0_next.wb = pair.b_inv_mass;
        it0_next.dx = DiffW'(pair.b_x) - DiffW'(pair.a_x);
        it0_next.dy = DiffW'(pair.b_y) - DiffW'(pair.a_y);
    end

    // stage 1: squares
    dcs_item_t       it1_reg;
    logic [SqW-1:0]  sx_next, sy_next, sx1_reg, sy1_reg;
    logic [CoordW-1:0] mx0, my0;

    assign mx0     = mag33(it0_reg.dx);
    assign my0     = mag33(it0_reg.dy);
    assign sx_next = mx0 * mx0;
    assign sy_next = my0 * my0;

    // stage 2: sum of squares
    dcs_item_t       it2_reg;
    logic [RadW-1:0] rad2_next, rad2_reg;

    assign rad2_next = RadW'(sx1_reg) + RadW'(sy1_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it0_reg  <= it0_next;
            it1_reg  <= it0_reg;
            sx1_reg  <= sx_next;
            sy1_reg  <= sy_next;
            it2_reg  <= it1_reg;
            rad2_reg <= rad2_next;
        end
    end

    // square root chain
    logic [RadW-1:0] sq_rad  [SqrtCells+1];
    logic [RemW-1:0] sq_rem  [SqrtCells+1];
    logic [LenW-1:0] sq_root [SqrtCells+1];
    dcs_item_t       sq_item [SqrtCells+1];

    assign sq_rad[0]  = rad2_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_item[0] = it2_reg;

    for (genvar k = 0; k < SqrtCells; k++)
    begin : g_sqrt
        dcs_item_t item_reg;

        dcs_sqrt_cell #(.PAIR(SqrtCells - 1 - k)) u_cell (
            .clk      (clk),
            .en       (adv),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .rad_out  (sq_rad[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
                item_reg <= sq_item[k];
        end

        assign sq_item[k+1] = item_reg;
    end

    // stage 3: length error
    dcs_item_t       it3_next, it3_reg;
    logic [LenW-1:0] dmag_next, dmag3_reg;
    logic [LenW-1:0] len_s, rest_ext;
    logic [TotW-1:0] total_s;

    always_comb
    begin
        len_s          = sq_root[SqrtCells];
        rest_ext       = LenW'(rest_length_reg);
        total_s        = TotW'(sq_item[SqrtCells].wa) + TotW'(sq_item[SqrtCells].wb);
        it3_next       = sq_item[SqrtCells];
        it3_next.len   = len_s;
        it3_next.grow  = len_s > rest_ext;
        it3_next.act   = (len_s != rest_ext) && (len_s != '0) && (total_s != '0);
        dmag_next      = (len_s > rest_ext) ? (len_s - rest_ext) : (rest_ext - len_s);
    end

    // stage 4: scale error by stiffness
    dcs_item_t                   it4_next, it4_reg;
    logic [LenW+StiffW-1:0]      corr_prod;

    always_comb
    begin
        corr_prod     = dmag3_reg * stiff_eff;
        it4_next      = it3_reg;
        it4_next.corr = corr_prod[LenW+ShareFrac-1:ShareFrac];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it3_reg   <= it3_next;
            dmag3_reg <= dmag_next;
            it4_reg   <= it4_next;
        end
    end

    // direction dividers, one chain per axis
    logic [LenW-1:0]  dxd_d [DirQW+1];
    logic [DirRW-1:0] dxd_r [DirQW+1];
    logic [DirQW-1:0] dxd_q [DirQW+1];
    logic [LenW-1:0]  dyd_d [DirQW+1];
    logic [DirRW-1:0] dyd_r [DirQW+1];
    logic [DirQW-1:0] dyd_q [DirQW+1];
    dcs_item_t        dd_item [DirQW+1];

    assign dxd_d[0]   = it4_reg.len;
    assign dxd_r[0]   = {1'b0, mag33(it4_reg.dx), {DirFrac{1'b0}}};
    assign dxd_q[0]   = '0;
    assign dyd_d[0]   = it4_reg.len;
    assign dyd_r[0]   = {1'b0, mag33(it4_reg.dy), {DirFrac{1'b0}}};
    assign dyd_q[0]   = '0;
    assign dd_item[0] = it4_reg;

    for (genvar k = 0; k < DirQW; k++)
    begin : g_dir
        dcs_item_t item_reg;

        dcs_div_cell #(.DW(LenW), .QW(DirQW), .SHIFT(DirQW - 1 - k)) u_xcell (
            .clk (clk), .en (adv),
            .d_in (dxd_d[k]), .r_in (dxd_r[k]), .q_in (dxd_q[k]),
            .d_out (dxd_d[k+1]), .r_out (dxd_r[k+1]), .q_out (dxd_q[k+1])
        );

        dcs_div_cell #(.DW(LenW), .QW(DirQW), .SHIFT(DirQW - 1 - k)) u_ycell (
            .clk (clk), .en (adv),
            .d_in (dyd_d[k]), .r_in (dyd_r[k]), .q_in (dyd_q[k]),
            .d_out (dyd_d[k+1]), .r_out (dyd_r[k+1]), .q_out (dyd_q[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
                item_reg <= dd_item[k];
        end

        assign dd_item[k+1] = item_reg;
    end

    // mass share dividers, aligned to end with the direction chains
    logic [TotW-1:0]    shd_d [ShareQW+1];
    logic [ShareRW-1:0] sha_r [ShareQW+1];
    logic [ShareQW-1:0] sha_q [ShareQW+1];
    logic [TotW-1:0]    shb_d_unused [ShareQW];
    logic [ShareRW-1:0] shb_r [ShareQW+1];
    logic [ShareQW-1:0] shb_q [ShareQW+1];
    logic [TotW-1:0]    total_d;

    // a total of zero is taken as one; such an item is not corrected anyway
    always_comb
    begin
        total_d = TotW'(dd_item[ShareOff].wa) + TotW'(dd_item[ShareOff].wb);
        if (total_d == '0)
            total_d = TotW'(1);
    end

    assign shd_d[0] = total_d;
    assign sha_r[0] = {1'b0, dd_item[ShareOff].wa, {ShareFrac{1'b0}}};
    assign sha_q[0] = '0;
    assign shb_r[0] = {1'b0, dd_item[ShareOff].wb, {ShareFrac{1'b0}}};
    assign shb_q[0] = '0;

    for (genvar j = 0; j < ShareQW; j++)
    begin : g_share
        dcs_div_cell #(.DW(TotW), .QW(ShareQW), .SHIFT(ShareQW - 1 - j)) u_acell (
            .clk (clk), .en (adv),
            .d_in (shd_d[j]), .r_in (sha_r[j]), .q_in (sha_q[j]),
            .d_out (shd_d[j+1]), .r_out (sha_r[j+1]), .q_out (sha_q[j+1])
        );

        dcs_div_cell #(.DW(TotW), .QW(ShareQW), .SHIFT(ShareQW - 1 - j)) u_bcell (
            .clk (clk), .en (adv),
            .d_in (shd_d[j]), .r_in (shb_r[j]), .q_in (shb_q[j]),
            .d_out (shb_d_unused[j]), .r_out (shb_r[j+1]), .q_out (shb_q[j+1])
        );
    end

    // stage 5: move = corr * dir
    dcs_item_t                it5_reg;
    logic [LenW-1:0]          movex5_reg, movey5_reg;
    logic [ShareQW-1:0]       sha5_reg, shb5_reg;
    logic [LenW+DirQW-1:0]    mvx_prod, mvy_prod;

    assign mvx_prod = dd_item[DirQW].corr * dxd_q[DirQW];
    assign mvy_prod = dd_item[DirQW].corr * dyd_q[DirQW];

    // stage 6: step = move * share
    dcs_item_t                it6_reg;
    logic [LenW-1:0]          stepax6_reg, stepay6_reg, stepbx6_reg, stepby6_reg;
    logic [LenW+ShareQW-1:0]  pax, pay, pbx, pby;

    assign pax = movex5_reg * sha5_reg;
    assign pay = movey5_reg * sha5_reg;
    assign pbx = movex5_reg * shb5_reg;
    assign pby = movey5_reg * shb5_reg;

    // stage 7: signed correction and saturation
    logic                     negx, negy;
    logic signed [SumW-1:0]   sax, say, sbx, sby;
    logic [CoordW-1:0]        nax_next, nay_next, nbx_next, nby_next;
    logic [CoordW-1:0]        nax7_reg, nay7_reg, nbx7_reg, nby7_reg;

    always_comb
    begin
        negx = it6_reg.dx[DiffW-1] != it6_reg.grow;
        negy = it6_reg.dy[DiffW-1] != it6_reg.grow;
        sax  = '0;
        say  = '0;
        sbx  = '0;
        sby  = '0;
        if (it6_reg.act)
        begin
            sax = negx ? -SumW'(stepax6_reg) : SumW'(stepax6_reg);
            say = negy ? -SumW'(stepay6_reg) : SumW'(stepay6_reg);
            sbx = negx ? -SumW'(stepbx6_reg) : SumW'(stepbx6_reg);
            sby = negy ? -SumW'(stepby6_reg) : SumW'(stepby6_reg);
        end
        nax_next = sat35(SumW'(it6_reg.ax) + sax);
        nay_next = sat35(SumW'(it6_reg.ay) + say);
        nbx_next = sat35(SumW'(it6_reg.bx) - sbx);
        nby_next = sat35(SumW'(it6_reg.by) - sby);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it5_reg     <= dd_item[DirQW];
            movex5_reg  <= mvx_prod[LenW+DirFrac-1:DirFrac];
            movey5_reg  <= mvy_prod[LenW+DirFrac-1:DirFrac];
            sha5_reg    <= sha_q[ShareQW];
            shb5_reg    <= shb_q[ShareQW];
            it6_reg     <= it5_reg;
            stepax6_reg <= pax[LenW+ShareFrac-1:ShareFrac];
            stepay6_reg <= pay[LenW+ShareFrac-1:ShareFrac];
            stepbx6_reg <= pbx[LenW+ShareFrac-1:ShareFrac];
            stepby6_reg <= pby[LenW+ShareFrac-1:ShareFrac];
            nax7_reg    <= nax_next;
            nay7_reg    <= nay_next;
            nbx7_reg    <= nbx_next;
            nby7_reg    <= nby_next;
        end
    end

    // output register
    logic [CoordW-1:0] oax_reg, oay_reg, obx_reg, oby_reg;

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            oax_reg <= nax7_reg;
            oay_reg <= nay7_reg;
            obx_reg <= nbx7_reg;
            oby_reg <= nby7_reg;
        end
    end

    assign result.valid   = out_v_reg;
    assign result.new_a_x = oax_reg;
    assign result.new_a_y = oay_reg;
    assign result.new_b_x = obx_reg;
    assign result.new_b_y = oby_reg;

endmodule

// File: design/dcs_chk.sv
// Port-level checks of the distance constraint solver, bound to the top level.
`include "distance_constraint_solver_top_assert.svh"

module dcs_chk import dcs_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              pair_ready,
    input logic              cfg_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic [CoordW-1:0] new_a_x,
    input logic [CoordW-1:0] new_a_y,
    input logic [CoordW-1:0] new_b_x,
    input logic [CoordW-1:0] new_b_y
);

    logic [4*CoordW-1:0] out_bus;

    assign out_bus = {new_a_x, new_a_y, new_b_x, new_b_y};

    // input side only stops while a result sits unread
    `DCS_ASSERT_NOW(a_stall_needs_result, clk, rst_n, !pair_ready, result_valid && !result_ready)

    `DCS_ASSERT_NOW(a_cfg_always_ready, clk, rst_n, 1'b1, cfg_ready)

    `DCS_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)

    `DCS_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && !result_ready, $stable(out_bus))

endmodule

bind distance_constraint_solver_top dcs_chk u_dcs_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_ready   (pair.ready),
    .cfg_ready    (cfg.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .new_a_x      (result.new_a_x),
    .new_a_y      (result.new_a_y),
    .new_b_x      (result.new_b_x),
    .new_b_y      (result.new_b_y)
);

// File: tb/dcs_tb_if.sv
// Item types of the testbench for pending pairs and expected results.
package dcs_tb_types;
    import dcs_pkg::*;

    typedef struct {
        logic signed [CoordW-1:0] ax;
        logic signed [CoordW-1:0] ay;
        logic signed [CoordW-1:0] bx;
        logic signed [CoordW-1:0] by;
        logic [MassW-1:0]         wa;
        logic [MassW-1:0]         wb;
    } pair_t;

    typedef struct {
        logic [CoordW-1:0] nax;
        logic [CoordW-1:0] nay;
        logic [CoordW-1:0] nbx;
        logic [CoordW-1:0] nby;
    } moved_t;
endpackage

// File: tb/testbench.sv
// Self-checking testbench of the distance constraint solver with a built-in predictor.
module testbench;
    import dcs_pkg::*;
    import dcs_tb_types::*;

    logic clk;
    logic rst_n;

    dcs_cfg_if cfg ();
    dcs_in_if  pair ();
    dcs_out_if result ();

    distance_constraint_solver_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .pair   (pair.sink),
        .result (result.source)
    );

    logic [RestW-1:0]  rest_len_q;
    logic [StiffW-1:0] stiff_q;
    pair_t             pending_pairs[$];
    moved_t            expected_moves[$];
    bit                failed;
    bit                in_taken;
    int                hold_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [33:0] root66(input logic [65:0] v);
        logic [33:0] root;
        logic [67:0] rem;
        logic [67:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem   = (rem << 2) | 68'(v[2*i +: 2]);
            trial = (68'(root) << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 34'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] axis_move(input logic signed [63:0] d,
        input logic [63:0] len, input logic [63:0] corr, input bit grow,
        input logic [63:0] share);
        logic [127:0] m;
        logic [127:0] dir;
        logic [127:0] mv;
        logic [127:0] st;
        m   = d < 0 ? 128'(-d) : 128'(d);
        dir = (m << 30) / 128'(len);
        mv  = (128'(corr) * dir) >> 30;
        st  = (mv * 128'(share)) >> 16;
        return ((d < 0) != grow) ? -$signed(64'(st)) : $signed(64'(st));
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic moved_t solve_pair(input pair_t p);
        logic signed [63:0] ax, ay, bx, by, dx, dy, nax, nay, nbx, nby;
        logic [65:0] sq;
        logic [63:0] len, total, stf, dmag, corr, sha, shb;
        bit grow;
        moved_t r;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        dx = bx - ax;
        dy = by - ay;
        // squares can exceed 2^63, so keep them unsigned before widening
        sq = 66'($unsigned(dx * dx)) + 66'($unsigned(dy * dy));
        len = 64'(root66(sq));
        total = 64'(p.wa) + 64'(p.wb);
        stf = stiff_q > StiffOne ? 64'(StiffOne) : 64'(stiff_q);
        nax = ax; nay = ay; nbx = bx; nby = by;
        if (len != 64'(rest_len_q) && len != 0 && total != 0)
        begin
            grow = len > 64'(rest_len_q);
            dmag = grow ? len - 64'(rest_len_q) : 64'(rest_len_q) - len;
            corr = (dmag * stf) >> 16;
            sha  = (64'(p.wa) << 16) / total;
            shb  = (64'(p.wb) << 16) / total;
            nax = ax + axis_move(dx, len, corr, grow, sha);
            nay = ay + axis_move(dy, len, corr, grow, sha);
            nbx = bx - axis_move(dx, len, corr, grow, shb);
            nby = by - axis_move(dy, len, corr, grow, shb);
        end
        r.nax = clamp32(nax);
        r.nay = clamp32(nay);
        r.nbx = clamp32(nbx);
        r.nby = clamp32(nby);
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            return 0;
        if (k < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rand_mass();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'hff_ffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // driver; in_taken tells whether the last rising edge accepted the item
    int send_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pair.valid <= 1'b0;
            send_gap = 0;
        end
        else if (!pair.valid || in_taken)
        begin
            if (pair.valid && in_taken)
                send_gap = gap_len();
            if (send_gap > 0 || hold_left > 0 || pending_pairs.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                pair.valid <= 1'b0;
            end
            else
            begin
                pair_t p;
                p = pending_pairs.pop_front();
                pair.a_x <= p.ax;
                pair.a_y <= p.ay;
                pair.b_x <= p.bx;
                pair.b_y <= p.by;
                pair.a_inv_mass <= p.wa;
                pair.b_inv_mass <= p.wb;
                pair.valid <= 1'b1;
            end
        end
    end

    // predictor at acceptance
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n && pair.valid && pair.ready)
        begin
            pair_t p;
            in_taken = 1'b1;
            p.ax = pair.a_x; p.ay = pair.a_y; p.bx = pair.b_x; p.by = pair.b_y;
            p.wa = pair.a_inv_mass; p.wb = pair.b_inv_mass;
            expected_moves.push_back(solve_pair(p));
        end
    end

    // receiver stalls
    int recv_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_gap = 0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            result.ready <= 1'b0;
        end
        else
        begin
            recv_gap = gap_len();
            result.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            moved_t e;
            if (expected_moves.size() == 0)
            begin
                $error("result with no expectation");
                failed = 1'b1;
            end
            else
            begin
                e = expected_moves.pop_front();
                if (result.new_a_x !== e.nax)
                begin
                    $error("new_a_x exp %h got %h", e.nax, result.new_a_x);
                    failed = 1'b1;
                end
                if (result.new_a_y !== e.nay)
                begin
                    $error("new_a_y exp %h got %h", e.nay, result.new_a_y);
                    failed = 1'b1;
                end
                if (result.new_b_x !== e.nbx)
                begin
                    $error("new_b_x exp %h got %h", e.nbx, result.new_b_x);
                    failed = 1'b1;
                end
                if (result.new_b_y !== e.nby)
                begin
                    $error("new_b_y exp %h got %h", e.nby, result.new_b_y);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic add_pair(input logic [31:0] ax, input logic [31:0] ay,
        input logic [31:0] bx, input logic [31:0] by, input logic [23:0] wa,
        input logic [23:0] wb);
        pair_t p;
        p.ax = ax; p.ay = ay; p.bx = bx; p.by = by; p.wa = wa; p.wb = wb;
        pending_pairs.push_back(p);
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || pair.valid || expected_moves.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(negedge clk);
        cfg.index <= idx;
        cfg.data  <= val;
        cfg.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == RegRestLength)
            rest_len_q = RestW'(val);
        else
            stiff_q = StiffW'(val);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        logic [31:0] ax, ay;
        for (int i = 0; i < n; i++)
        begin
            ax = rand_coord();
            ay = rand_coord();
            if ($urandom_range(0, 3) == 0)
                add_pair(ax, ay, rand_coord(), rand_coord(), rand_mass(), rand_mass());
            else
                // near pairs: distance close to typical rest lengths
                add_pair(ax, ay, ax + ($urandom_range(0, 32'h0010_0000) - 32'h0008_0000),
                    ay + ($urandom_range(0, 32'h0010_0000) - 32'h0008_0000),
                    rand_mass(), rand_mass());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        failed = 1'b0;
        in_taken = 1'b0;
        hold_left = 0;
        rest_len_q = '0;
        stiff_q = StiffOne;
        cfg.valid = 1'b0;
        cfg.index = RegRestLength;
        cfg.data = '0;
        pair.valid = 1'b0;
        pair.a_x = '0; pair.a_y = '0; pair.b_x = '0; pair.b_y = '0;
        pair.a_inv_mass = '0; pair.b_inv_mass = '0;
        result.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(RegRestLength, 31'h0001_0000);
        write_reg(RegStiffness, 31'(StiffOne));
        // exact rest length, coincident, both fixed, extremes
        add_pair(32'h0, 32'h0, 32'h0001_0000, 32'h0, 24'h1_0000, 24'h1_0000);
        add_pair(32'h0012_3456, 32'h0, 32'h0012_3456, 32'h0, 24'h1_0000, 24'h1_0000);
        add_pair(32'h0, 32'h0, 32'h0005_0000, 32'h0003_0000, 24'h0, 24'h0);
        add_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            24'hff_ffff, 24'hff_ffff);
        add_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            24'hff_ffff, 24'h0);
        add_pair(32'h0, 32'h0, 32'h0000_4000, 32'hffff_c000, 24'h0, 24'h1);
        add_pair(32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff, 24'h8000, 24'h1);
        add_pair(32'h7fff_0000, 32'h0, 32'h8000_0000, 32'h0, 24'h1_0000, 24'h3_0000);
        wait_drained();

        write_reg(RegRestLength, 31'h7fff_ffff);
        write_reg(RegStiffness, 31'h1_ffff);
        add_pair(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 24'h1_0000, 24'h1_0000);
        add_pair(32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0, 24'h1, 24'hff_ffff);
        random_phase(300);
        wait_drained();

        write_reg(RegRestLength, 31'h0);
        write_reg(RegStiffness, 31'h0);
        random_phase(200);
        wait_drained();

        write_reg(RegRestLength, 31'($urandom_range(0, 32'h000c_0000)));
        write_reg(RegStiffness, 31'($urandom_range(0, 65536)));
        random_phase(250);
        // sender holds until all results are back
        wait_drained();
        random_phase(250);
        wait_drained();

        write_reg(RegRestLength, 31'($urandom));
        write_reg(RegStiffness, 31'h8000);
        random_phase(250);
        wait_drained();
        repeat (100) @(posedge clk);
        if (failed || expected_moves.size() != 0)
            $display("** distance_constraint_solver_top: FAILED **");
        else
            $display("** distance_constraint_solver_top: PASSED **");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("** distance_constraint_solver_top: FAILED **");
        $finish;
    end
endmodule
